[rtl/acbs_pkg.sv]
// shared constants, codes and field layout for the anchored clipped blit setup block
package acbs_pkg;

    // row stride in bytes is 2**ROW_STRIDE_SHIFT
    localparam int ROW_STRIDE_SHIFT = 10;

    localparam int ADDR_W  = 24;
    localparam int COORD_W = 11;
    localparam int SIZE_W  = 9;
    localparam int COUNT_W = 10;
    localparam int CODE_W  = 2;
    localparam int REG_W   = 9;
    localparam int IDX_W   = 3;

    // signed working width for anchored coordinates and right or bottom ends
    localparam int WORK_W = COORD_W + 1;

    localparam int IN_W     = 2 * COORD_W + 6 * SIZE_W + 4 * CODE_W;
    localparam int IN_PAD_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W    = CODE_W + 2 * ADDR_W + 2 * COUNT_W;
    localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [ADDR_W-1:0] SCREEN0_BASE = 24'hC00000;
    localparam logic [ADDR_W-1:0] SCREEN1_BASE = 24'hC80000;

    localparam logic [REG_W-1:0] LEFT_BOUND_RST     = 9'd0;
    localparam logic [REG_W-1:0] RIGHT_BOUND_RST    = 9'd511;
    localparam logic [REG_W-1:0] DRAW_TOP_RST       = 9'd0;
    localparam logic [REG_W-1:0] HIDDEN_TOP_RST     = 9'd256;
    localparam logic [REG_W-1:0] VISIBLE_HEIGHT_RST = 9'd256;

    typedef enum logic [IDX_W-1:0] {
        REG_LEFT_BOUND     = 3'd0,
        REG_RIGHT_BOUND    = 3'd1,
        REG_DRAW_TOP       = 3'd2,
        REG_HIDDEN_TOP     = 3'd3,
        REG_VISIBLE_HEIGHT = 3'd4
    } reg_index_t;

    typedef enum logic [CODE_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_OUTSIDE  = 2'd2
    } status_t;

    localparam logic [CODE_W-1:0] ANCHOR_START = 2'd0;
    localparam logic [CODE_W-1:0] ANCHOR_END   = 2'd2;

    localparam logic [CODE_W-1:0] CLIP_DRAW    = 2'd0;
    localparam logic [CODE_W-1:0] CLIP_OFFSET  = 2'd2;

endpackage

[rtl/anchored_clipped_blit_setup_top.sv]
// anchored clipped blit setup: anchor, size check, window clip and address generation
//
// path: a request accepted into the input register has its result loaded into the result
//   register, from which it can be taken on m_tdata
// throughput: one request per cycle; input register and result register each
//   advance whenever the stage after them is empty or being drained
// reset: aresetn low at a clock edge empties both stages and loads the clip
//   registers with their reset values; nothing else needs clearing
module anchored_clipped_blit_setup_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // command channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // dest_x, dest_y, dest_width, dest_height, source_x, source_y,
    // source_width, source_height, screen_select, clip_mode,
    // vertical_anchor, horizontal_anchor, zero pad
    input  logic [acbs_pkg::IN_PAD_W-1:0]      s_tdata,
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status, dest_address, source_address, run_width, row_count, zero pad
    output logic [acbs_pkg::OUT_PAD_W-1:0]     m_tdata,
    // clip register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acbs_pkg::IDX_W-1:0]         cfg_index,
    input  logic [acbs_pkg::REG_W-1:0]         cfg_data
);

    localparam int AW = acbs_pkg::ADDR_W;
    localparam int WW = acbs_pkg::WORK_W;
    localparam int DW = WW + 1;  // width of differences between working values

    // clip registers
    logic [acbs_pkg::REG_W-1:0] left_bound_reg;
    logic [acbs_pkg::REG_W-1:0] right_bound_reg;
    logic [acbs_pkg::REG_W-1:0] draw_top_reg;
    logic [acbs_pkg::REG_W-1:0] hidden_top_reg;
    logic [acbs_pkg::REG_W-1:0] visible_height_reg;

    // pipeline registers
    logic                          in_valid_reg;
    logic [acbs_pkg::IN_W-1:0]     in_data_reg;
    logic                          out_valid_reg;
    logic [acbs_pkg::OUT_W-1:0]    out_data_reg;
    logic [acbs_pkg::OUT_W-1:0]    out_data_next;

    logic out_adv;
    logic in_adv;

    // result stage takes a new value when empty or drained this cycle
    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(acbs_pkg::OUT_PAD_W - acbs_pkg::OUT_W){1'b0}}, out_data_reg};
    assign cfg_ready = 1'b1;

    // clip register writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_bound_reg     <= acbs_pkg::LEFT_BOUND_RST;
            right_bound_reg    <= acbs_pkg::RIGHT_BOUND_RST;
            draw_top_reg       <= acbs_pkg::DRAW_TOP_RST;
            hidden_top_reg     <= acbs_pkg::HIDDEN_TOP_RST;
            visible_height_reg <= acbs_pkg::VISIBLE_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                acbs_pkg::REG_LEFT_BOUND:     left_bound_reg     <= cfg_data;
                acbs_pkg::REG_RIGHT_BOUND:    right_bound_reg    <= cfg_data;
                acbs_pkg::REG_DRAW_TOP:       draw_top_reg       <= cfg_data;
                acbs_pkg::REG_HIDDEN_TOP:     hidden_top_reg     <= cfg_data;
                acbs_pkg::REG_VISIBLE_HEIGHT: visible_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_adv) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_adv && s_tvalid) begin
            in_data_reg <= s_tdata[acbs_pkg::IN_W-1:0];
        end
        if (out_adv && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    // unpack the registered command
    logic signed [acbs_pkg::COORD_W-1:0] dest_x;
    logic signed [acbs_pkg::COORD_W-1:0] dest_y;
    logic [acbs_pkg::SIZE_W-1:0] dest_width;
    logic [acbs_pkg::SIZE_W-1:0] dest_height;
    logic [acbs_pkg::SIZE_W-1:0] source_x;
    logic [acbs_pkg::SIZE_W-1:0] source_y;
    logic [acbs_pkg::SIZE_W-1:0] source_width;
    logic [acbs_pkg::SIZE_W-1:0] source_height;
    logic [acbs_pkg::CODE_W-1:0] screen_select;
    logic [acbs_pkg::CODE_W-1:0] clip_mode;
    logic [acbs_pkg::CODE_W-1:0] vertical_anchor;
    logic [acbs_pkg::CODE_W-1:0] horizontal_anchor;

    assign {horizontal_anchor, vertical_anchor, clip_mode, screen_select,
            source_height, source_width, source_y, source_x,
            dest_height, dest_width, dest_y, dest_x} = in_data_reg;

    // anchored rectangle, signed working width
    logic signed [WW-1:0] dw_s;
    logic signed [WW-1:0] dh_s;
    logic signed [WW-1:0] x0;
    logic signed [WW-1:0] y0;
    logic signed [WW-1:0] x_end;
    logic signed [WW-1:0] y_end;

    // clip window
    logic signed [WW-1:0] xmin;
    logic signed [WW-1:0] xmax;
    logic signed [WW-1:0] ymin;
    logic signed [WW-1:0] ymax;
    logic [acbs_pkg::REG_W:0] ymax_u;

    // clipped values
    logic signed [WW-1:0] x_clip;
    logic signed [WW-1:0] y_clip;
    logic signed [WW-1:0] x_end_clip;
    logic signed [WW-1:0] y_end_clip;
    logic signed [DW-1:0] sx_clip;
    logic signed [DW-1:0] sy_clip;
    logic signed [DW-1:0] run_diff;
    logic signed [DW-1:0] row_diff;
    logic [acbs_pkg::CODE_W-1:0] status;

    logic [AW-1:0] dest_base;
    logic [AW-1:0] source_base;
    logic [AW-1:0] dest_address;
    logic [AW-1:0] source_address;
    logic [acbs_pkg::COUNT_W-1:0] run_width;
    logic [acbs_pkg::COUNT_W-1:0] row_count;

    assign dw_s = $signed({{(WW - acbs_pkg::SIZE_W){1'b0}}, dest_width});
    assign dh_s = $signed({{(WW - acbs_pkg::SIZE_W){1'b0}}, dest_height});

    // anchor shift: start keeps, end moves by the full size, else by half
    always_comb begin
        case (vertical_anchor)
            acbs_pkg::ANCHOR_START: y0 = WW'(dest_y);
            acbs_pkg::ANCHOR_END:   y0 = WW'(dest_y) - dh_s;
            default:                y0 = WW'(dest_y) - (dh_s >>> 1);
        endcase
        case (horizontal_anchor)
            acbs_pkg::ANCHOR_START: x0 = WW'(dest_x);
            acbs_pkg::ANCHOR_END:   x0 = WW'(dest_x) - dw_s;
            default:                x0 = WW'(dest_x) - (dw_s >>> 1);
        endcase
    end

    assign x_end = x0 + dw_s;
    assign y_end = y0 + dh_s;

    // window select; mode three falls in with the hidden page window
    always_comb begin
        case (clip_mode)
            acbs_pkg::CLIP_DRAW: begin
                ymin   = $signed(WW'(draw_top_reg));
                ymax_u = (acbs_pkg::REG_W + 1)'(visible_height_reg);
            end
            acbs_pkg::CLIP_OFFSET: begin
                ymin   = $signed(WW'(draw_top_reg));
                ymax_u = (acbs_pkg::REG_W + 1)'(draw_top_reg)
                       + (acbs_pkg::REG_W + 1)'(visible_height_reg);
            end
            default: begin
                ymin   = $signed(WW'(hidden_top_reg));
                ymax_u = (acbs_pkg::REG_W + 1)'(hidden_top_reg)
                       + (acbs_pkg::REG_W + 1)'(visible_height_reg);
            end
        endcase
    end

    assign ymax = $signed(WW'(ymax_u));
    assign xmin = $signed(WW'(left_bound_reg));
    assign xmax = $signed(WW'(right_bound_reg));

    // clip, horizontal first and then vertical, in priority order
    always_comb begin
        x_clip     = x0;
        y_clip     = y0;
        x_end_clip = x_end;
        y_end_clip = y_end;
        sx_clip    = $signed(DW'(source_x));
        sy_clip    = $signed(DW'(source_y));
        status     = acbs_pkg::STATUS_OK;

        if (x_end < xmin) begin
            status = acbs_pkg::STATUS_OUTSIDE;
        end else if (x0 < xmin) begin
            sx_clip = $signed(DW'(source_x)) + DW'(xmin) - DW'(x0);
            x_clip  = xmin;
        end else if (x_end > xmax) begin
            // may leave a negative run when the left edge is already past
            x_end_clip = xmax;
        end

        if (status == acbs_pkg::STATUS_OK) begin
            if (y_end < ymin) begin
                status = acbs_pkg::STATUS_OUTSIDE;
            end else if (y0 < ymin) begin
                sy_clip = $signed(DW'(source_y)) + DW'(ymin) - DW'(y0);
                y_clip  = ymin;
            end else if (y0 < ymax && y_end > ymax) begin
                y_end_clip = ymax;
            end else if (y0 > ymax) begin
                status = acbs_pkg::STATUS_OUTSIDE;
            end
        end

        // size check outranks any clip result
        if (source_width != dest_width || source_height != dest_height) begin
            status = acbs_pkg::STATUS_MISMATCH;
        end
    end

    assign dest_base   = screen_select[0] ? acbs_pkg::SCREEN1_BASE : acbs_pkg::SCREEN0_BASE;
    assign source_base = screen_select[1] ? acbs_pkg::SCREEN1_BASE : acbs_pkg::SCREEN0_BASE;

    // start corners are non-negative once the command passes the clip
    assign dest_address = dest_base
                        + (AW'(y_clip[WW-2:0]) << acbs_pkg::ROW_STRIDE_SHIFT)
                        + (AW'(x_clip[WW-2:0]) << 1);
    assign source_address = source_base
                          + (AW'(sy_clip[DW-2:0]) << acbs_pkg::ROW_STRIDE_SHIFT)
                          + (AW'(sx_clip[DW-2:0]) << 1);

    assign run_diff = DW'(x_end_clip) - DW'(x_clip);
    assign row_diff = DW'(y_end_clip) - DW'(y_clip);

    // negative extents become zero
    assign run_width = run_diff[DW-1] ? '0 : run_diff[acbs_pkg::COUNT_W-1:0];
    assign row_count = row_diff[DW-1] ? '0 : row_diff[acbs_pkg::COUNT_W-1:0];

    // rejected commands carry only the status
    always_comb begin
        if (status == acbs_pkg::STATUS_OK) begin
            out_data_next = {row_count, run_width, source_address, dest_address, status};
        end else begin
            out_data_next = {{(acbs_pkg::OUT_W - acbs_pkg::CODE_W){1'b0}}, status};
        end
    end

`ifndef SYNTHESIS
    // a rejected result has all other fields zero
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[acbs_pkg::CODE_W-1:0] != acbs_pkg::STATUS_OK)
        |-> (out_data_reg[acbs_pkg::OUT_W-1:acbs_pkg::CODE_W] == '0))
        else $error("rejected result carries nonzero fields");

    // an accepted result address is always pixel aligned
    a_dest_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[acbs_pkg::CODE_W-1:0] == acbs_pkg::STATUS_OK)
        |-> (out_data_reg[acbs_pkg::CODE_W] == 1'b0))
        else $error("destination address not pixel aligned");

    // input stage stalls only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // a request in the input stage moves to the result stage when it advances
    a_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_adv) |=> out_valid_reg)
        else $error("request lost between stages");

    // status is never the unused code
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg) |-> (status != 2'd3))
        else $error("unused status code produced");
`endif

endmodule
